@@ hw/rtl/glbq_pkg.sv @@
// ----------------------------------------------------------------------------
// glbq_pkg
// Shared constants, payload codes and controller/datapath handshake structs
// for the grey-level bucket queue.
// ----------------------------------------------------------------------------
package glbq_pkg;

  localparam int LEVELS      = 256;
  localparam int STORE_DEPTH = 65536;

  localparam int LVL_W  = 8;                       // level field width
  localparam int IDX_W  = $clog2(LEVELS);          // level memory index
  localparam int LOW_W  = IDX_W + 1;               // lowest level, with "none"
  localparam int PIX_W  = 16;
  localparam int CNT_W  = 17;                      // counts, bases, fills
  localparam int SUM_W  = CNT_W + 1;
  localparam int SLOT_W = $clog2(STORE_DEPTH);
  localparam int LANE_W = IDX_W / 2;
  localparam int GRP_W  = IDX_W - LANE_W;
  localparam int LANES  = 1 << LANE_W;
  localparam int GROUPS = 1 << GRP_W;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] fill;
  } level_rec_t;

  typedef struct packed {
    logic capture;   // take the input transfer, read the level record
    logic exec;      // update level record, slot store, flags
    logic scan_grp;  // find first nonempty group
    logic scan_bit;  // find first nonempty level within the group
    logic load_out;  // fill the output register
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_pix;
  } stat_t;

endpackage

@@ hw/rtl/glbq_if.sv @@
// ----------------------------------------------------------------------------
// glbq_if
// Valid/ready channels of the grey-level bucket queue: operation input and
// result output.
// ----------------------------------------------------------------------------
interface glbq_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [glbq_pkg::LVL_W-1:0] level;
  logic [glbq_pkg::PIX_W-1:0] pixel_in;
  logic [glbq_pkg::CNT_W-1:0] bin_count;

  modport source (output valid, op, level, pixel_in, bin_count, input ready);
  modport sink   (input valid, op, level, pixel_in, bin_count, output ready);
endinterface

interface glbq_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [glbq_pkg::PIX_W-1:0] pixel_out;
  logic [glbq_pkg::LVL_W-1:0] lowest_level;
  logic                     lowest_valid;

  modport source (output valid, status, pixel_out, lowest_level, lowest_valid,
                  input ready);
  modport sink   (input valid, status, pixel_out, lowest_level, lowest_valid,
                  output ready);
endinterface

@@ hw/rtl/grey_level_bucket_queue.sv @@
// ----------------------------------------------------------------------------
// grey_level_bucket_queue
// Bucket priority queue of pixel indices keyed by grey level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one operation per transfer: load a level's histogram count
//          (gives the level a stack region placed by running prefix sum, the
//          sum restarting at level 0), push a pixel, or pop a level's newest
//          pixel. Every operation yields exactly one result on out_ch:
//          status, popped pixel, and the lowest nonempty level after it.
//   Each operation is captured, then executed; a push, a failed pop or an
//   unused code is answered from the execute step, a pop that leaves its
//   level nonempty adds a step for the slot store read, and a load or a pop
//   that empties its level adds the two-step level rescan.
//   One item is in work at a time; the level record memory is read on the
//   transfer and written back in the cycle after, which sets the sequence.
//   The output register lets a new transfer in while the previous result is
//   still waiting; if out_ch stalls, the finished result holds in the
//   datapath and in_ch.ready stays low until the output register frees.
//   Reset clears all level records (valid bits), nonempty flags, the running
//   base and the lowest level; no clearing pass. Slot store contents are
//   undefined until pushed.
// ----------------------------------------------------------------------------
module grey_level_bucket_queue (
  input  logic              clk,
  input  logic              rst_n,
  glbq_in_if.sink           in_ch,
  glbq_out_if.source        out_ch
);

  glbq_pkg::cmd_t  cmd;
  glbq_pkg::stat_t stat;

  // Sequence each operation: capture, execute, optional rescan, emit
  glbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold level records, slot store and output payload
  glbq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_ch.op),
    .in_level   (in_ch.level),
    .in_pixel   (in_ch.pixel_in),
    .in_count   (in_ch.bin_count),
    .out_status (out_ch.status),
    .out_pixel  (out_ch.pixel_out),
    .out_level  (out_ch.lowest_level),
    .out_lvalid (out_ch.lowest_valid)
  );

endmodule

@@ hw/rtl/glbq_ctrl.sv @@
// ----------------------------------------------------------------------------
// glbq_ctrl
// Sequencer of the bucket queue: accepts one operation, steps the datapath
// through update and rescan, and owns the output valid flag.
// ----------------------------------------------------------------------------
module glbq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output glbq_pkg::cmd_t  cmd,
  input  glbq_pkg::stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCANG = 5'b00100,
    S_SCANB = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_scan) begin
          state_nxt = S_SCANG;
        end else if (stat.need_pix || !out_free) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCANG: begin
        cmd.scan_grp = 1'b1;
        state_nxt    = S_SCANB;
      end
      S_SCANB: begin
        cmd.scan_bit = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/glbq_dp.sv @@
// ----------------------------------------------------------------------------
// glbq_dp
// Datapath of the bucket queue: level record memory with valid bits, slot
// store, nonempty flags, two-step lowest-level encoder and output register.
// ----------------------------------------------------------------------------
module glbq_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  glbq_pkg::cmd_t             cmd,
  output glbq_pkg::stat_t            stat,
  input  logic [1:0]                 in_op,
  input  logic [glbq_pkg::LVL_W-1:0] in_level,
  input  logic [glbq_pkg::PIX_W-1:0] in_pixel,
  input  logic [glbq_pkg::CNT_W-1:0] in_count,
  output logic [1:0]                 out_status,
  output logic [glbq_pkg::PIX_W-1:0] out_pixel,
  output logic [glbq_pkg::LVL_W-1:0] out_level,
  output logic                       out_lvalid
);

  // Lowest set bit of one group of flags.
  function automatic logic [glbq_pkg::LANE_W-1:0] first_set(
    input logic [glbq_pkg::LANES-1:0] v
  );
    logic [glbq_pkg::LANE_W-1:0] idx;
    idx = '0;
    for (int i = glbq_pkg::LANES - 1; i >= 0; i--) begin
      if (v[i]) idx = glbq_pkg::LANE_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [glbq_pkg::GRP_W-1:0] first_grp(
    input logic [glbq_pkg::GROUPS-1:0] v
  );
    logic [glbq_pkg::GRP_W-1:0] idx;
    idx = '0;
    for (int i = glbq_pkg::GROUPS - 1; i >= 0; i--) begin
      if (v[i]) idx = glbq_pkg::GRP_W'(i);
    end
    return idx;
  endfunction

  // Item registers
  glbq_pkg::op_t              op_r;
  logic [glbq_pkg::LVL_W-1:0] lvl_r;
  logic [glbq_pkg::PIX_W-1:0] pix_r;
  logic [glbq_pkg::CNT_W-1:0] cnt_r;

  // Level records
  glbq_pkg::level_rec_t       lvl_mem [glbq_pkg::LEVELS];
  glbq_pkg::level_rec_t       rec_rd_r;
  logic                       vld_rd_r;
  logic [glbq_pkg::LEVELS-1:0] lvl_vld_r;
  logic [glbq_pkg::LEVELS-1:0] ne_r;
  logic [glbq_pkg::CNT_W-1:0] run_base_r, run_base_nxt;
  logic [glbq_pkg::LOW_W-1:0] lowest_r, lowest_nxt;

  // Slot store
  logic [glbq_pkg::PIX_W-1:0] slot_mem [glbq_pkg::STORE_DEPTH];
  logic [glbq_pkg::PIX_W-1:0] slot_rd_r;
  logic                       pix_ok_r;

  // Scan registers
  logic [glbq_pkg::GRP_W-1:0]  grp_r;
  logic                        grp_hit_r;
  logic [glbq_pkg::GROUPS-1:0] grp_any;
  logic [glbq_pkg::LANES-1:0]  lanes;

  glbq_pkg::status_t          st_r, st_comb;

  // Execute-cycle logic
  glbq_pkg::level_rec_t       rec, rec_new;
  logic                       rec_we;
  logic [glbq_pkg::IDX_W-1:0] lvl_idx;
  logic                       in_range;
  logic [glbq_pkg::SUM_W-1:0] push_sum, pop_sum, load_sum;
  logic [glbq_pkg::CNT_W-1:0] fill_dec, load_base;
  logic                       push_ok, pop_ok;
  logic [glbq_pkg::SLOT_W-1:0] slot_addr;

  assign lvl_idx  = lvl_r[glbq_pkg::IDX_W-1:0];
  assign in_range = {1'b0, lvl_r} < glbq_pkg::LOW_W'(glbq_pkg::LEVELS);
  assign rec      = vld_rd_r ? rec_rd_r : '0;

  always_comb begin
    push_sum  = {1'b0, rec.base} + {1'b0, rec.fill};
    fill_dec  = rec.fill - glbq_pkg::CNT_W'(1);
    pop_sum   = {1'b0, rec.base} + {1'b0, fill_dec};
    load_base = (lvl_r == '0) ? '0 : run_base_r;
    load_sum  = {1'b0, load_base} + {1'b0, cnt_r};
    push_ok   = in_range && (rec.fill < rec.cap)
                && (push_sum < glbq_pkg::SUM_W'(glbq_pkg::STORE_DEPTH));
    pop_ok    = in_range && (rec.fill != '0);
    slot_addr = (op_r == glbq_pkg::OP_PUSH) ? push_sum[glbq_pkg::SLOT_W-1:0]
                                            : pop_sum[glbq_pkg::SLOT_W-1:0];
    if (load_sum > glbq_pkg::SUM_W'(glbq_pkg::STORE_DEPTH)) begin
      run_base_nxt = glbq_pkg::CNT_W'(glbq_pkg::STORE_DEPTH);
    end else begin
      run_base_nxt = load_sum[glbq_pkg::CNT_W-1:0];
    end

    rec_new        = rec;
    rec_we         = 1'b0;
    st_comb        = glbq_pkg::ST_OK;
    stat.need_scan = 1'b0;
    stat.need_pix  = 1'b0;
    case (op_r)
      glbq_pkg::OP_LOAD: begin
        if (in_range) begin
          rec_we         = 1'b1;
          rec_new.base   = load_base;
          rec_new.cap    = cnt_r;
          rec_new.fill   = '0;
          stat.need_scan = 1'b1;
        end
      end
      glbq_pkg::OP_PUSH: begin
        if (push_ok) begin
          rec_we       = 1'b1;
          rec_new.fill = rec.fill + glbq_pkg::CNT_W'(1);
        end else begin
          st_comb = glbq_pkg::ST_FULL;
        end
      end
      glbq_pkg::OP_POP: begin
        if (pop_ok) begin
          rec_we         = 1'b1;
          rec_new.fill   = fill_dec;
          stat.need_pix  = 1'b1;
          stat.need_scan = (fill_dec == '0);
        end else begin
          st_comb = glbq_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // Item capture and record read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= glbq_pkg::op_t'(in_op);
      lvl_r    <= in_level;
      pix_r    <= in_pixel;
      cnt_r    <= in_count;
      rec_rd_r <= lvl_mem[in_level[glbq_pkg::IDX_W-1:0]];
      vld_rd_r <= lvl_vld_r[in_level[glbq_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && rec_we) begin
      lvl_mem[lvl_idx] <= rec_new;
    end
  end

  // Slot store: write on push, read on pop
  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == glbq_pkg::OP_PUSH && push_ok) begin
      slot_mem[slot_addr] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      slot_rd_r <= slot_mem[slot_addr];
      st_r      <= st_comb;
    end
  end

  // Clear at capture so non-pop results return a zero pixel
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_ok_r <= 1'b0;
    end else if (cmd.exec) begin
      pix_ok_r <= (op_r == glbq_pkg::OP_POP) && pop_ok
                  && (pop_sum < glbq_pkg::SUM_W'(glbq_pkg::STORE_DEPTH));
    end
  end

  // Level flags, running base, lowest level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_vld_r  <= '0;
      ne_r       <= '0;
      run_base_r <= '0;
      lowest_r   <= glbq_pkg::LOW_W'(glbq_pkg::LEVELS);
    end else begin
      lowest_r <= lowest_nxt;
      if (cmd.exec && rec_we) begin
        lvl_vld_r[lvl_idx] <= 1'b1;
        case (op_r)
          glbq_pkg::OP_LOAD: begin
            ne_r[lvl_idx] <= 1'b0;
            run_base_r    <= run_base_nxt;
          end
          glbq_pkg::OP_PUSH: ne_r[lvl_idx] <= 1'b1;
          glbq_pkg::OP_POP:  ne_r[lvl_idx] <= (fill_dec != '0);
          default: begin
          end
        endcase
      end
    end
  end

  // Two-step priority encoder: group first, then level within the group
  always_comb begin
    for (int g = 0; g < glbq_pkg::GROUPS; g++) begin
      grp_any[g] = |ne_r[g*glbq_pkg::LANES +: glbq_pkg::LANES];
    end
  end

  assign lanes = ne_r[{grp_r, {glbq_pkg::LANE_W{1'b0}}} +: glbq_pkg::LANES];

  always_ff @(posedge clk) begin
    if (cmd.scan_grp) begin
      grp_r     <= first_grp(grp_any);
      grp_hit_r <= |grp_any;
    end
  end

  always_comb begin
    lowest_nxt = lowest_r;
    if (cmd.exec && op_r == glbq_pkg::OP_PUSH && push_ok
        && ({1'b0, lvl_r} < lowest_r)) begin
      lowest_nxt = {1'b0, lvl_r};
    end
    if (cmd.scan_bit) begin
      lowest_nxt = grp_hit_r ? {1'b0, grp_r, first_set(lanes)}
                             : glbq_pkg::LOW_W'(glbq_pkg::LEVELS);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.exec ? st_comb : st_r;
      out_pixel  <= pix_ok_r ? slot_rd_r : '0;
      if (lowest_nxt != glbq_pkg::LOW_W'(glbq_pkg::LEVELS)) begin
        out_level  <= lowest_nxt[glbq_pkg::LVL_W-1:0];
        out_lvalid <= 1'b1;
      end else begin
        out_level  <= '0;
        out_lvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/glbq_checker.sv @@
// ----------------------------------------------------------------------------
// glbq_checker
// Port-level checks of the bucket queue, bound to the top level.
// ----------------------------------------------------------------------------
module glbq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [glbq_pkg::PIX_W-1:0] out_pixel,
  input logic [glbq_pkg::LVL_W-1:0] out_level,
  input logic                       out_lvalid
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_pixel) && $stable(out_level) && $stable(out_lvalid))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // No result appears in the cycle after a transfer into a drained output
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind grey_level_bucket_queue glbq_checker u_glbq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_pixel  (out_ch.pixel_out),
  .out_level  (out_ch.lowest_level),
  .out_lvalid (out_ch.lowest_valid)
);

@@ tb/bucket_queue_checker.sv @@
// ----------------------------------------------------------------------------
// bucket_queue_checker
// Watches the operation and result channels of the grey-level bucket queue.
// Keeps its own copy of the level records and slot store, predicts every
// result, and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module bucket_queue_checker
  import glbq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  glbq_in_if   in_mon,
  glbq_out_if  out_mon,
  output int   error_count,
  output int   results_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic [PIX_W-1:0] pixel;
    logic [LVL_W-1:0] lowest_level;
    logic             lowest_valid;
  } bucket_result_t;

  logic [PIX_W-1:0] slot_mem [STORE_DEPTH];
  logic [CNT_W-1:0] lvl_base [LEVELS];
  logic [CNT_W-1:0] lvl_fill [LEVELS];
  logic [CNT_W-1:0] lvl_cap  [LEVELS];
  logic [CNT_W-1:0] next_base;
  logic [LOW_W-1:0] lowest_seen;

  bucket_result_t pending_results [$];

  function automatic logic [LOW_W-1:0] first_nonempty();
    logic [LOW_W-1:0] found;
    found = LOW_W'(LEVELS);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (lvl_fill[i] != '0) found = LOW_W'(i);
    end
    return found;
  endfunction

  // Apply one operation to the model state and return the result it yields.
  function automatic bucket_result_t bucket_step(op_t op, logic [LVL_W-1:0] lv,
                                                 logic [PIX_W-1:0] px,
                                                 logic [CNT_W-1:0] cnt);
    bucket_result_t res;
    logic [SUM_W-1:0] slot;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_LOAD: begin
        if (lv == '0) next_base = '0;
        lvl_base[lv] = next_base;
        lvl_cap[lv]  = cnt;
        lvl_fill[lv] = '0;
        slot = {1'b0, next_base} + {1'b0, cnt};
        if (slot > SUM_W'(STORE_DEPTH)) slot = SUM_W'(STORE_DEPTH);
        next_base = slot[CNT_W-1:0];
        lowest_seen = first_nonempty();
      end
      OP_PUSH: begin
        slot = {1'b0, lvl_base[lv]} + {1'b0, lvl_fill[lv]};
        if (lvl_fill[lv] >= lvl_cap[lv] || slot >= SUM_W'(STORE_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          slot_mem[slot[SLOT_W-1:0]] = px;
          lvl_fill[lv] = lvl_fill[lv] + 1'b1;
          if ({1'b0, lv} < lowest_seen) lowest_seen = {1'b0, lv};
        end
      end
      OP_POP: begin
        if (lvl_fill[lv] == '0) begin
          res.status = ST_EMPTY;
        end else begin
          lvl_fill[lv] = lvl_fill[lv] - 1'b1;
          slot = {1'b0, lvl_base[lv]} + {1'b0, lvl_fill[lv]};
          if (slot < SUM_W'(STORE_DEPTH)) res.pixel = slot_mem[slot[SLOT_W-1:0]];
          if (lvl_fill[lv] == '0) lowest_seen = first_nonempty();
        end
      end
      default: ;
    endcase
    res.lowest_valid = lowest_seen < LOW_W'(LEVELS);
    res.lowest_level = res.lowest_valid ? lowest_seen[LVL_W-1:0] : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    bucket_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        lvl_base[i] = '0;
        lvl_fill[i] = '0;
        lvl_cap[i]  = '0;
      end
      next_base   = '0;
      lowest_seen = LOW_W'(LEVELS);
      pending_results.delete();
      error_count <= 0;
      results_pending <= 0;
    end else begin
      // Compare first: a result can never belong to an operation taken
      // on the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          if (error_count < 10)
            $display("[%0t] unexpected result: status=%0d pixel=%h low=%0d/%0b", $time,
                     out_mon.status, out_mon.pixel_out, out_mon.lowest_level,
                     out_mon.lowest_valid);
          error_count <= error_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_mon.status !== want.status || out_mon.pixel_out !== want.pixel ||
              out_mon.lowest_level !== want.lowest_level ||
              out_mon.lowest_valid !== want.lowest_valid) begin
            if (error_count < 10)
              $display("[%0t] result mismatch: expected status=%0d pixel=%h low=%0d/%0b, got status=%0d pixel=%h low=%0d/%0b",
                       $time, want.status, want.pixel, want.lowest_level,
                       want.lowest_valid, out_mon.status, out_mon.pixel_out,
                       out_mon.lowest_level, out_mon.lowest_valid);
            error_count <= error_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(bucket_step(op_t'(in_mon.op), in_mon.level,
                                              in_mon.pixel_in, in_mon.bin_count));
      results_pending <= pending_results.size();
    end
  end

endmodule

@@ tb/grey_level_bucket_queue_test.sv @@
// ----------------------------------------------------------------------------
// grey_level_bucket_queue_test
// Drives loads, pushes, pops and unused codes into the bucket queue: a
// directed opening over the corner cases, then random frames of histogram
// loads followed by push/pop traffic, mixed with noise. The checker beside
// the block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module grey_level_bucket_queue_test;

  import glbq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1200;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 20;    // longest item ends with the level rescan

  logic clk = 1'b0;
  logic rst_n;

  glbq_in_if  op_ch ();
  glbq_out_if res_ch ();

  int fail_count;
  int results_pending;
  int items_sent;
  int burst_left;
  bit valid_held;     // mirrors the last value put on op_ch.valid
  int idle_cycles;

  always #6 clk = ~clk;

  grey_level_bucket_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_ch),
    .out_ch (res_ch)
  );

  bucket_queue_checker pred_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (op_ch),
    .out_mon         (res_ch),
    .error_count     (fail_count),
    .results_pending (results_pending)
  );

  // Count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (!rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: end the run if the block stops moving.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Receiver: stall on patterns of random length. Modes are long open
  // stretches, coin-flip backpressure, solid stalls and strict alternation.
  initial begin
    int mode;
    int left;
    bit toggle;
    res_ch.ready <= 1'b0;
    left = 0;
    mode = 0;
    toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        case (mode)
          0: left = $urandom_range(10, 60);
          1: left = $urandom_range(10, 40);
          2: left = $urandom_range(1, 25);
          default: left = $urandom_range(8, 30);
        endcase
      end
      left--;
      toggle = ~toggle;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= 1'b0;
        default: res_ch.ready <= toggle;
      endcase
    end
  end

  // Offer one operation and hold it until the transfer. Afterwards either
  // keep valid high for the next item of the burst or drop it for a gap.
  task automatic send_item(op_t op, logic [LVL_W-1:0] lv, logic [PIX_W-1:0] px,
                           logic [CNT_W-1:0] cnt);
    int gap;
    op_ch.valid     <= 1'b1;
    op_ch.op        <= op;
    op_ch.level     <= lv;
    op_ch.pixel_in  <= px;
    op_ch.bin_count <= cnt;
    valid_held = 1'b1;
    do @(posedge clk); while (!op_ch.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      // One burst in four runs straight into the next one.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        op_ch.valid <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [PIX_W-1:0] any_pixel();
    return PIX_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CNT_W-1:0] any_count();
    return CNT_W'($urandom_range(0, 131071));
  endfunction

  // Noise: any code, any level, any field values.
  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_item(op_t'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 255)),
                any_pixel(), any_count());
  endtask

  // One image's worth of traffic: load a few histogram bins (usually
  // restarting the layout at level 0), then push and pop on those levels.
  task automatic run_frame();
    logic [LVL_W-1:0] frame_levels [$];
    logic [LVL_W-1:0] lv;
    logic [CNT_W-1:0] cnt;
    int pick;
    if ($urandom_range(0, 3) != 0) begin
      send_item(OP_LOAD, '0, any_pixel(), CNT_W'($urandom_range(0, 8)));
      frame_levels.push_back('0);
    end
    repeat ($urandom_range(1, 7)) begin
      lv = LVL_W'($urandom_range(0, 255));
      // Mostly small bins; now and then a huge one to push the layout
      // toward the end of the slot store.
      cnt = ($urandom_range(0, 15) == 0) ? any_count() : CNT_W'($urandom_range(0, 12));
      send_item(OP_LOAD, lv, any_pixel(), cnt);
      frame_levels.push_back(lv);
    end
    repeat ($urandom_range(10, 60)) begin
      pick = $urandom_range(0, 99);
      lv = frame_levels[$urandom_range(0, frame_levels.size() - 1)];
      if (pick < 55)
        send_item(OP_PUSH, lv, any_pixel(), any_count());
      else if (pick < 95)
        send_item(OP_POP, lv, any_pixel(), any_count());
      else
        send_item(op_t'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 255)),
                  any_pixel(), any_count());
    end
  endtask

  initial begin
    items_sent = 0;
    burst_left = 0;
    valid_held = 1'b0;
    rst_n           <= 1'b0;
    op_ch.valid     <= 1'b0;
    op_ch.op        <= OP_NONE;
    op_ch.level     <= '0;
    op_ch.pixel_in  <= '0;
    op_ch.bin_count <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: pop reports empty, push to an unloaded level is full.
    send_item(OP_POP, 8'd0, 16'h0000, 17'h00000);
    send_item(OP_PUSH, 8'd255, 16'hFFFF, 17'h00000);
    // Unused code with every field busy changes nothing.
    send_item(OP_NONE, 8'hAA, 16'h5555, 17'h1FFFF);
    // Lay out level 0, the top level and a zero-size bin.
    send_item(OP_LOAD, 8'd0, 16'h0000, 17'd3);
    send_item(OP_LOAD, 8'd255, 16'h0000, 17'd2);
    send_item(OP_LOAD, 8'd128, 16'h0000, 17'd0);
    send_item(OP_PUSH, 8'd128, 16'h1111, 17'd0);     // zero capacity
    send_item(OP_PUSH, 8'd255, 16'hFFFF, 17'd0);
    send_item(OP_PUSH, 8'd255, 16'h0000, 17'd0);
    send_item(OP_PUSH, 8'd255, 16'h1234, 17'd0);     // past capacity
    send_item(OP_PUSH, 8'd0, 16'hA5A5, 17'd0);       // lowest drops to 0
    send_item(OP_POP, 8'd0, 16'h0000, 17'd0);        // empties, rescan
    send_item(OP_POP, 8'd255, 16'h0000, 17'd0);
    send_item(OP_POP, 8'd255, 16'h0000, 17'd0);      // queue empty again
    send_item(OP_POP, 8'd255, 16'h0000, 17'd0);
    // Fill the slot store with one bin so the next region starts past its
    // end: pushes there are refused even with capacity left.
    send_item(OP_LOAD, 8'd0, 16'h0000, 17'h10000);
    send_item(OP_LOAD, 8'd1, 16'h0000, 17'h1FFFF);
    send_item(OP_PUSH, 8'd1, 16'h7777, 17'd0);
    send_item(OP_LOAD, 8'd2, 16'h0000, 17'h10000);
    send_item(OP_PUSH, 8'd0, 16'h8001, 17'd0);
    send_item(OP_PUSH, 8'd0, 16'h7FFE, 17'd0);
    // Reload a nonempty level: its stack is dropped and the lowest rescans.
    send_item(OP_LOAD, 8'd0, 16'hFFFF, 17'd5);
    send_item(OP_POP, 8'd0, 16'h0000, 17'd0);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0)
        run_noise();
      else
        run_frame();
    end
    if (valid_held) op_ch.valid <= 1'b0;

    // Drain: let the checker count the last transfer, wait for every
    // predicted result, then watch for strays.
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
